/* sv/bcl_pkg.sv */
`timescale 1ns / 1ps

package bcl_pkg;

   // Configuration port geometry.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_LIMIT   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_TICKS     = 2'd2;

   // Register field widths.
   localparam int DEBOUNCE_LIMIT_W   = 6;
   localparam int LONG_PRESS_LIMIT_W = 8;
   localparam int WINDOW_TICKS_W     = 8;

   // Register values after reset.
   localparam logic [DEBOUNCE_LIMIT_W-1:0]   DEBOUNCE_LIMIT_RST   = 6'd5;
   localparam logic [LONG_PRESS_LIMIT_W-1:0] LONG_PRESS_LIMIT_RST = 8'd70;
   localparam logic [WINDOW_TICKS_W-1:0]     WINDOW_TICKS_RST     = 8'd100;

   // Working state widths. The press timer can reach one beyond the
   // largest long press limit, so it needs one extra bit.
   localparam int CLICK_W = 4;
   localparam int TIMER_W = LONG_PRESS_LIMIT_W + 1;

   localparam logic [CLICK_W-1:0] CLICK_MAX = 4'd15;

   // One result as it sits in the output stages.
   typedef struct packed {
      logic               long_press;
      logic [CLICK_W-1:0] click_count;
   } rsp_payload_type;

endpackage

/* sv/bcl_channels.sv */
`timescale 1ns / 1ps

// Request channel: one button level sample per tick.
interface bcl_req_if;
   logic valid;
   logic ready;
   logic pressed_sample;

   modport source (output valid, output pressed_sample, input ready);
   modport sink   (input valid, input pressed_sample, output ready);
endinterface

// Result channel: one report at the end of each window.
interface bcl_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           long_press;
   logic [bcl_pkg::CLICK_W-1:0]    click_count;

   modport source (output valid, output long_press, output click_count, input ready);
   modport sink   (input valid, input long_press, input click_count, output ready);
endinterface

/* sv/button_click_and_long_press_detector_unit.sv */
`timescale 1ns / 1ps

// Channel    Direction  Handshake         Payload
// req        in         valid / ready     pressed_sample
// rsp        out        valid / ready     long_press, click_count
// csr        in         csr_we            csr_index, csr_wdata
//
// One request is taken every clock cycle while req.ready is high. A window
// report is registered in the result register, or in the skid register
// while rsp stalls. Debounce, press timer and window counters update once
// per accepted request. A two-entry output stage (result plus skid register)
// lets requests continue while a report waits; req.ready drops only while
// both entries are full. Reset is synchronous and clears all control state.
module button_click_and_long_press_detector_unit (
   input  logic                                clock,
   input  logic                                reset,
   bcl_req_if.sink                             req,
   bcl_rsp_if.source                           rsp,
   input  logic                                csr_we,
   input  logic [bcl_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bcl_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // Configuration registers.
   logic [bcl_pkg::DEBOUNCE_LIMIT_W-1:0]   debounce_limit_ff;
   logic [bcl_pkg::LONG_PRESS_LIMIT_W-1:0] long_press_limit_ff;
   logic [bcl_pkg::WINDOW_TICKS_W-1:0]     window_ticks_ff;

   // Detector state.
   logic                                   window_active_ff, window_active_in;
   logic                                   debounced_level_ff, debounced_level_in;
   logic [bcl_pkg::DEBOUNCE_LIMIT_W-1:0]   debounce_counter_ff, debounce_counter_in;
   logic [bcl_pkg::TIMER_W-1:0]            press_timer_ff, press_timer_in;
   logic [bcl_pkg::WINDOW_TICKS_W-1:0]     tick_counter_ff, tick_counter_in;
   logic [bcl_pkg::CLICK_W-1:0]            clicks_ff, clicks_in;

   // Output stages.
   logic                                   out_valid_ff;
   bcl_pkg::rsp_payload_type               out_data_ff;
   logic                                   skid_valid_ff;
   bcl_pkg::rsp_payload_type               skid_data_ff;

   logic                                   req_accept;
   logic                                   result_fire;
   bcl_pkg::rsp_payload_type               result_data;

   assign req.ready  = !skid_valid_ff;
   assign req_accept = req.valid && req.ready;

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_limit_ff   <= bcl_pkg::DEBOUNCE_LIMIT_RST;
         long_press_limit_ff <= bcl_pkg::LONG_PRESS_LIMIT_RST;
         window_ticks_ff     <= bcl_pkg::WINDOW_TICKS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            bcl_pkg::CSR_DEBOUNCE_LIMIT:
               debounce_limit_ff <= csr_wdata[bcl_pkg::DEBOUNCE_LIMIT_W-1:0];
            bcl_pkg::CSR_LONG_PRESS_LIMIT:
               long_press_limit_ff <= csr_wdata[bcl_pkg::LONG_PRESS_LIMIT_W-1:0];
            bcl_pkg::CSR_WINDOW_TICKS:
               window_ticks_ff <= csr_wdata[bcl_pkg::WINDOW_TICKS_W-1:0];
            default: ;
         endcase
      end
   end

   // Per-tick update: window open, debounce, press timer and window end.
   always_comb begin
      logic                                 level;
      logic                                 base_level;
      logic [bcl_pkg::DEBOUNCE_LIMIT_W-1:0] base_counter;
      logic [bcl_pkg::TIMER_W-1:0]          base_timer;
      logic [bcl_pkg::WINDOW_TICKS_W-1:0]   base_ticks;
      logic [bcl_pkg::CLICK_W-1:0]          base_clicks;

      level = req.pressed_sample;

      window_active_in    = window_active_ff;
      debounced_level_in  = debounced_level_ff;
      debounce_counter_in = debounce_counter_ff;
      press_timer_in      = press_timer_ff;
      tick_counter_in     = tick_counter_ff;
      clicks_in           = clicks_ff;
      result_fire         = 1'b0;
      result_data.long_press  = 1'b0;
      result_data.click_count = clicks_ff;

      // A pressed sample while idle opens a window with one click.
      if (window_active_ff) begin
         base_level   = debounced_level_ff;
         base_counter = debounce_counter_ff;
         base_timer   = press_timer_ff;
         base_ticks   = tick_counter_ff;
         base_clicks  = clicks_ff;
      end else begin
         base_level   = 1'b1;
         base_counter = '0;
         base_timer   = '0;
         base_ticks   = '0;
         base_clicks  = 4'd1;
      end

      if (req_accept && (window_active_ff || level)) begin
         window_active_in    = 1'b1;
         debounced_level_in  = base_level;
         debounce_counter_in = base_counter;
         clicks_in           = base_clicks;

         // Debounce: disagreement counts up until the level flips.
         if (level != base_level) begin
            if (base_counter < debounce_limit_ff) begin
               debounce_counter_in = base_counter + 1'b1;
            end else begin
               debounce_counter_in = '0;
               debounced_level_in  = level;
               if (level && (base_clicks < bcl_pkg::CLICK_MAX)) begin
                  clicks_in = base_clicks + 1'b1;
               end
            end
         end else if (base_counter != '0) begin
            debounce_counter_in = base_counter - 1'b1;
         end

         result_data.click_count = clicks_in;
         tick_counter_in = base_ticks;
         press_timer_in  = base_timer;

         // Press timer: a hold past the limit ends the window at once.
         priority if (debounced_level_in &&
                      (base_timer > {1'b0, long_press_limit_ff})) begin
            window_active_in       = 1'b0;
            result_fire            = 1'b1;
            result_data.long_press = 1'b1;
         end else begin
            if (debounced_level_in) begin
               press_timer_in = base_timer + 1'b1;
            end else if (base_timer != '0) begin
               press_timer_in = base_timer - 1'b1;
            end

            // Window length, counted modulo the counter width.
            tick_counter_in = base_ticks + 1'b1;
            if (tick_counter_in >= window_ticks_ff) begin
               window_active_in = 1'b0;
               result_fire      = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_active_ff    <= 1'b0;
         debounced_level_ff  <= 1'b0;
         debounce_counter_ff <= '0;
         press_timer_ff      <= '0;
         tick_counter_ff     <= '0;
         clicks_ff           <= '0;
      end else begin
         window_active_ff    <= window_active_in;
         debounced_level_ff  <= debounced_level_in;
         debounce_counter_ff <= debounce_counter_in;
         press_timer_ff      <= press_timer_in;
         tick_counter_ff     <= tick_counter_in;
         clicks_ff           <= clicks_in;
      end
   end

   // Output stages: a new report goes to the skid register only while the
   // result register holds one that is not being taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && !rsp.ready) begin
            if (result_fire) begin
               skid_valid_ff <= 1'b1;
            end
         end else if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= result_fire;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_valid_ff && !rsp.ready) begin
         if (result_fire) begin
            skid_data_ff <= result_data;
         end
      end else if (skid_valid_ff) begin
         out_data_ff <= skid_data_ff;
      end else if (result_fire) begin
         out_data_ff <= result_data;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.long_press  = out_data_ff.long_press;
   assign rsp.click_count = out_data_ff.click_count;

endmodule
